>>> hdl/jdq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package jdq_pkg;

  localparam int AXIS_W = 10;
  localparam int MS_W   = 16;
  localparam int TIME_W = 32;
  localparam int IDX_W  = 3;
  localparam int CFG_W  = 16;

  typedef enum logic [2:0] {
    EV_NONE  = 3'd0,
    EV_UP    = 3'd1,
    EV_DOWN  = 3'd2,
    EV_LEFT  = 3'd3,
    EV_RIGHT = 3'd4,
    EV_PRESS = 3'd5
  } event_t;

  localparam logic [IDX_W-1:0] CFG_AXIS_CENTER     = 3'd0;
  localparam logic [IDX_W-1:0] CFG_AXIS_THRESHOLD  = 3'd1;
  localparam logic [IDX_W-1:0] CFG_DEBOUNCE_MS     = 3'd2;
  localparam logic [IDX_W-1:0] CFG_REPEAT_FIRST_MS = 3'd3;
  localparam logic [IDX_W-1:0] CFG_REPEAT_NEXT_MS  = 3'd4;

  localparam logic [AXIS_W-1:0] RST_AXIS_CENTER     = 10'd512;
  localparam logic [AXIS_W-1:0] RST_AXIS_THRESHOLD  = 10'd200;
  localparam logic [MS_W-1:0]   RST_DEBOUNCE_MS     = 16'd50;
  localparam logic [MS_W-1:0]   RST_REPEAT_FIRST_MS = 16'd300;
  localparam logic [MS_W-1:0]   RST_REPEAT_NEXT_MS  = 16'd150;

  typedef struct packed {
    logic [AXIS_W-1:0] axis_center;
    logic [AXIS_W-1:0] axis_threshold;
    logic [MS_W-1:0]   debounce_ms;
    logic [MS_W-1:0]   repeat_first_ms;
    logic [MS_W-1:0]   repeat_next_ms;
  } cfg_t;

endpackage
`default_nettype wire

>>> hdl/jdq_classify.sv
`timescale 1ns / 1ps
`default_nettype none
module jdq_classify (
  input  wire jdq_pkg::cfg_t                 cfg,
  input  wire logic [jdq_pkg::AXIS_W-1:0]    horz_sample,
  input  wire logic [jdq_pkg::AXIS_W-1:0]    vert_sample,
  output jdq_pkg::event_t                    dir
);

  logic [jdq_pkg::AXIS_W:0] hi_bound;
  logic [jdq_pkg::AXIS_W:0] horz_plus;
  logic [jdq_pkg::AXIS_W:0] vert_plus;
  logic [jdq_pkg::AXIS_W:0] center_ext;

  // x < center - thr rewritten as x + thr < center, so a negative bound never trips
  assign hi_bound   = {1'b0, cfg.axis_center} + {1'b0, cfg.axis_threshold};
  assign horz_plus  = {1'b0, horz_sample} + {1'b0, cfg.axis_threshold};
  assign vert_plus  = {1'b0, vert_sample} + {1'b0, cfg.axis_threshold};
  assign center_ext = {1'b0, cfg.axis_center};

  always_comb begin
    if ({1'b0, vert_sample} > hi_bound) begin
      dir = jdq_pkg::EV_UP;
    end else if (vert_plus < center_ext) begin
      dir = jdq_pkg::EV_DOWN;
    end else if ({1'b0, horz_sample} > hi_bound) begin
      dir = jdq_pkg::EV_LEFT;
    end else if (horz_plus < center_ext) begin
      dir = jdq_pkg::EV_RIGHT;
    end else begin
      dir = jdq_pkg::EV_NONE;
    end
  end

endmodule
`default_nettype wire

>>> hdl/jdq_core.sv
`timescale 1ns / 1ps
`default_nettype none
module jdq_core (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          step_en,
  input  wire jdq_pkg::cfg_t                 cfg,
  input  wire jdq_pkg::event_t               dir,
  input  wire logic                          select_level,
  input  wire logic [jdq_pkg::TIME_W-1:0]    time_ms,
  output jdq_pkg::event_t                    ev
);

  logic                          prev_sel_r, prev_sel_nxt;
  logic                          stable_sel_r, stable_sel_nxt;
  logic [jdq_pkg::TIME_W-1:0]    change_time_r, change_time_nxt;
  jdq_pkg::event_t               held_dir_r, held_dir_nxt;
  logic                          await_first_r, await_first_nxt;
  logic [jdq_pkg::TIME_W-1:0]    fire_time_r, fire_time_nxt;

  logic [jdq_pkg::TIME_W-1:0]    sel_elapsed;
  logic [jdq_pkg::TIME_W-1:0]    hold_elapsed;
  logic [jdq_pkg::MS_W-1:0]      limit;
  logic                          press;

  always_comb begin
    prev_sel_nxt    = select_level;
    stable_sel_nxt  = stable_sel_r;
    change_time_nxt = (select_level != prev_sel_r) ? time_ms : change_time_r;
    held_dir_nxt    = held_dir_r;
    await_first_nxt = await_first_r;
    fire_time_nxt   = fire_time_r;
    ev              = jdq_pkg::EV_NONE;

    sel_elapsed  = time_ms - change_time_nxt;
    hold_elapsed = time_ms - fire_time_r;
    limit        = await_first_r ? cfg.repeat_first_ms : cfg.repeat_next_ms;
    press        = 1'b0;

    if ((sel_elapsed > {{(jdq_pkg::TIME_W-jdq_pkg::MS_W){1'b0}}, cfg.debounce_ms}) &&
        (select_level != stable_sel_r)) begin
      stable_sel_nxt = select_level;
      press          = !select_level;
    end

    // a debounced press pre-empts direction handling for this beat
    if (press) begin
      ev = jdq_pkg::EV_PRESS;
    end else if (dir == jdq_pkg::EV_NONE) begin
      held_dir_nxt    = jdq_pkg::EV_NONE;
      await_first_nxt = 1'b0;
    end else if (dir != held_dir_r) begin
      held_dir_nxt    = dir;
      await_first_nxt = 1'b1;
      fire_time_nxt   = time_ms;
      ev              = dir;
    end else if (hold_elapsed > {{(jdq_pkg::TIME_W-jdq_pkg::MS_W){1'b0}}, limit}) begin
      await_first_nxt = 1'b0;
      fire_time_nxt   = time_ms;
      ev              = dir;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_sel_r    <= 1'b1;
      stable_sel_r  <= 1'b1;
      change_time_r <= '0;
      held_dir_r    <= jdq_pkg::EV_NONE;
      await_first_r <= 1'b0;
      fire_time_r   <= '0;
    end else if (step_en) begin
      prev_sel_r    <= prev_sel_nxt;
      stable_sel_r  <= stable_sel_nxt;
      change_time_r <= change_time_nxt;
      held_dir_r    <= held_dir_nxt;
      await_first_r <= await_first_nxt;
      fire_time_r   <= fire_time_nxt;
    end
  end

endmodule
`default_nettype wire

>>> hdl/joystick_direction_qualifier_unit.sv
// a beat taken into the input stage has its event registered in the result stage as it advances,
// which waits while out_stall holds a full result stage; throughput: one beat per cycle when not
// stalled, set by the single-pass event logic between the two registers
// the event state is read and written in the same cycle, so back-to-back beats chain directly
// reset (synchronous, rst_n low): both stages empty, config registers at their defaults,
// select taken as released, no held direction
`timescale 1ns / 1ps
`default_nettype none
module joystick_direction_qualifier_unit (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [jdq_pkg::AXIS_W-1:0]    in_horz_sample,
  input  wire logic [jdq_pkg::AXIS_W-1:0]    in_vert_sample,
  input  wire logic                          in_select_level,
  input  wire logic [jdq_pkg::TIME_W-1:0]    in_time_ms,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [2:0]                         out_direction_event,
  input  wire logic                          cfg_wr_en,
  input  wire logic [jdq_pkg::IDX_W-1:0]     cfg_index,
  input  wire logic [jdq_pkg::CFG_W-1:0]     cfg_wdata
);

  jdq_pkg::cfg_t                 cfg_r;

  logic                          in_v_r;
  logic [jdq_pkg::AXIS_W-1:0]    horz_r;
  logic [jdq_pkg::AXIS_W-1:0]    vert_r;
  logic                          sel_r;
  logic [jdq_pkg::TIME_W-1:0]    time_r;

  logic                          out_v_r;
  jdq_pkg::event_t               out_ev_r;

  logic                          in_take;
  logic                          advance;
  jdq_pkg::event_t               dir;
  jdq_pkg::event_t               ev;

  assign advance  = in_v_r && (!out_v_r || !out_stall);
  assign in_stall = in_v_r && out_v_r && out_stall;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.axis_center     <= jdq_pkg::RST_AXIS_CENTER;
      cfg_r.axis_threshold  <= jdq_pkg::RST_AXIS_THRESHOLD;
      cfg_r.debounce_ms     <= jdq_pkg::RST_DEBOUNCE_MS;
      cfg_r.repeat_first_ms <= jdq_pkg::RST_REPEAT_FIRST_MS;
      cfg_r.repeat_next_ms  <= jdq_pkg::RST_REPEAT_NEXT_MS;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        jdq_pkg::CFG_AXIS_CENTER:     cfg_r.axis_center     <= cfg_wdata[jdq_pkg::AXIS_W-1:0];
        jdq_pkg::CFG_AXIS_THRESHOLD:  cfg_r.axis_threshold  <= cfg_wdata[jdq_pkg::AXIS_W-1:0];
        jdq_pkg::CFG_DEBOUNCE_MS:     cfg_r.debounce_ms     <= cfg_wdata;
        jdq_pkg::CFG_REPEAT_FIRST_MS: cfg_r.repeat_first_ms <= cfg_wdata;
        jdq_pkg::CFG_REPEAT_NEXT_MS:  cfg_r.repeat_next_ms  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_take) begin
      in_v_r <= 1'b1;
    end else if (advance) begin
      in_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      horz_r <= in_horz_sample;
      vert_r <= in_vert_sample;
      sel_r  <= in_select_level;
      time_r <= in_time_ms;
    end
  end

  jdq_classify u_classify (
    .cfg         (cfg_r),
    .horz_sample (horz_r),
    .vert_sample (vert_r),
    .dir         (dir)
  );

  jdq_core u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .step_en      (advance),
    .cfg          (cfg_r),
    .dir          (dir),
    .select_level (sel_r),
    .time_ms      (time_r),
    .ev           (ev)
  );

  // result stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (advance) begin
      out_v_r <= 1'b1;
    end else if (!out_stall) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_ev_r <= ev;
    end
  end

  assign out_valid           = out_v_r;
  assign out_direction_event = out_ev_r;

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (in_v_r && out_v_r && out_stall))
    else $error("input stalled without a blocked result");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid straight after reset");

  a_advance_fills: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> (out_valid && !$stable(in_v_r) || out_valid))
    else $error("processed beat did not reach the result stage");

  a_event_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_direction_event <= jdq_pkg::EV_PRESS))
    else $error("event code out of range");

endmodule
`default_nettype wire
